// ===== rtl/core/mrtu_pkg.sv =====
// shared types, constants and crc function for the modbus rtu master frame engine
package mrtu_pkg;

  localparam int PAYLOAD_LEN = 4;
  localparam int FRAME_LEN   = PAYLOAD_LEN + 4;
  localparam int BODY_LEN    = FRAME_LEN - 2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0]  PAYLOAD_BASE = 8'h61;
  localparam logic [7:0]  EXC_BIT      = 8'h80;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  localparam logic [1:0] OP_SEND   = 2'd0;
  localparam logic [1:0] OP_RX     = 2'd1;
  localparam logic [1:0] OP_TXDONE = 2'd2;

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    JOB_CMD,
    JOB_VERDICT,
    JOB_VERDICT_ERR
  } job_mode_t;

  typedef struct packed {
    job_mode_t  mode;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       acc;
    logic       exc;
    logic       fm;
    logic       cm;
    logic       alarm;
  } job_t;

  // modbus crc-16 over one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mrtu_front.sv =====
// front end: accepts requests, keeps link state, classifies work into jobs
module mrtu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_slave_addr,
  input  logic [7:0]         in_function_code,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_first,
  input  logic               q_full,
  output logic               push,
  output mrtu_pkg::job_t     job
);
  import mrtu_pkg::*;

  logic [7:0]  last_slave_r, last_slave_nxt;
  logic [7:0]  last_func_r, last_func_nxt;
  logic        pend_r, pend_nxt;
  logic        alarm_r, alarm_nxt;
  logic [3:0]  rx_cnt_r, rx_cnt_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [7:0]  hdr_addr_r, hdr_addr_nxt;
  logic [7:0]  hdr_func_r, hdr_func_nxt;
  logic [7:0]  hdr_crclo_r, hdr_crclo_nxt;

  logic        acc;
  logic [3:0]  eff_cnt;
  logic [15:0] eff_crc;
  logic        fm, cm;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign eff_cnt  = in_frame_first ? 4'd0 : rx_cnt_r;
  assign eff_crc  = in_frame_first ? CRC_INIT : rx_crc_r;
  assign fm       = hdr_func_r != last_func_r;
  assign cm       = (hdr_crclo_r != eff_crc[7:0]) || (in_rx_byte != eff_crc[15:8]);

  always_comb begin
    last_slave_nxt = last_slave_r;
    last_func_nxt  = last_func_r;
    pend_nxt       = pend_r;
    alarm_nxt      = alarm_r;
    rx_cnt_nxt     = rx_cnt_r;
    rx_crc_nxt     = rx_crc_r;
    hdr_addr_nxt   = hdr_addr_r;
    hdr_func_nxt   = hdr_func_r;
    hdr_crclo_nxt  = hdr_crclo_r;
    push           = 1'b0;
    job            = '0;
    job.mode       = JOB_CMD;
    job.alarm      = alarm_r;
    if (acc) begin
      case (in_op)
        OP_SEND: begin
          if (!pend_r) begin
            push     = 1'b1;
            job.b0   = in_slave_addr;
            job.b1   = in_function_code;
            pend_nxt = 1'b1;
          end
          last_slave_nxt = in_slave_addr;
          last_func_nxt  = in_function_code;
        end
        OP_RX: begin
          if (in_frame_first) begin
            rx_cnt_nxt = 4'd0;
            rx_crc_nxt = CRC_INIT;
          end
          if (eff_cnt < 4'(BODY_LEN)) begin
            rx_crc_nxt = crc_byte(eff_crc, in_rx_byte);
            if (eff_cnt == 4'd0) hdr_addr_nxt = in_rx_byte;
            if (eff_cnt == 4'd1) hdr_func_nxt = in_rx_byte;
            rx_cnt_nxt = eff_cnt + 4'd1;
          end else if (eff_cnt == 4'(BODY_LEN)) begin
            hdr_crclo_nxt = in_rx_byte;
            rx_cnt_nxt    = eff_cnt + 4'd1;
          end else if (eff_cnt == 4'(FRAME_LEN - 1)) begin
            rx_cnt_nxt = eff_cnt + 4'd1;
            push       = 1'b1;
            job.mode   = JOB_VERDICT;
            if (hdr_addr_r != last_slave_r) begin
              job.acc = 1'b0;
            end else if ((hdr_func_r & EXC_BIT) != 8'h00) begin
              alarm_nxt = 1'b1;
              job.exc   = 1'b1;
              job.alarm = 1'b1;
            end else begin
              job.fm  = fm;
              job.cm  = cm;
              job.acc = !(fm || cm);
              if ((fm || cm) && !pend_r) begin
                job.mode = JOB_VERDICT_ERR;
                job.b0   = last_slave_r;
                job.b1   = hdr_func_r | EXC_BIT;
                pend_nxt = 1'b1;
              end
            end
          end
        end
        OP_TXDONE: begin
          pend_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_slave_r <= '0;
      last_func_r  <= '0;
      pend_r       <= 1'b0;
      alarm_r      <= 1'b0;
      rx_cnt_r     <= '0;
      rx_crc_r     <= CRC_INIT;
    end else begin
      last_slave_r <= last_slave_nxt;
      last_func_r  <= last_func_nxt;
      pend_r       <= pend_nxt;
      alarm_r      <= alarm_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      rx_crc_r     <= rx_crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_addr_r  <= hdr_addr_nxt;
    hdr_func_r  <= hdr_func_nxt;
    hdr_crclo_r <= hdr_crclo_nxt;
  end

endmodule

// ===== rtl/core/mrtu_queue.sv =====
// short job queue between front and back
module mrtu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mrtu_pkg::job_t wdata,
  input  logic           pop,
  output mrtu_pkg::job_t rdata,
  output logic           full,
  output logic           empty
);
  import mrtu_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = cnt_r == (QAW+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== rtl/core/mrtu_back.sv =====
// back end: expands jobs into verdict and frame byte results with running crc
module mrtu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mrtu_pkg::job_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [7:0]     out_tx_byte,
  output logic           out_last,
  output logic           out_accepted,
  output logic           out_exception_seen,
  output logic           out_function_mismatch,
  output logic           out_crc_mismatch,
  output logic           out_alarm
);
  import mrtu_pkg::*;

  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic        kind_r, last_r, acc_r, exc_r, fm_r, cm_r, alarm_r;
  logic [7:0]  byte_r;

  logic        load, is_verdict, is_last;
  logic [2:0]  fb;
  logic [7:0]  body;

  assign load = !q_empty && (!valid_r || out_ready);
  assign pop  = load && is_last;

  always_comb begin
    fb         = (head.mode == JOB_CMD) ? step_r[2:0] : 3'(step_r - 4'd1);
    is_verdict = (head.mode != JOB_CMD) && (step_r == 4'd0);
    case (head.mode)
      JOB_CMD:         is_last = step_r == 4'(FRAME_LEN - 1);
      JOB_VERDICT:     is_last = 1'b1;
      JOB_VERDICT_ERR: is_last = step_r == 4'(FRAME_LEN);
      default:         is_last = 1'b1;
    endcase
    case (fb)
      3'd0: body = head.b0;
      3'd1: body = head.b1;
      3'd3: body = (head.mode == JOB_CMD) ? 8'(PAYLOAD_BASE + 8'd1) : {7'd0, head.fm};
      3'd4: body = (head.mode == JOB_CMD) ? 8'(PAYLOAD_BASE + 8'd2) : {7'd0, head.cm};
      3'd2: body = (head.mode == JOB_CMD) ? PAYLOAD_BASE : 8'h00;
      3'd5: body = (head.mode == JOB_CMD) ? 8'(PAYLOAD_BASE + 8'd3) : 8'h00;
      3'd6: body = crc_r[7:0];
      3'd7: body = crc_r[15:8];
      default: body = 8'h00;
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    crc_nxt   = crc_r;
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (is_last) begin
        step_nxt = '0;
        crc_nxt  = CRC_INIT;
      end else begin
        step_nxt = step_r + 4'd1;
        if (!is_verdict && fb < 3'(BODY_LEN)) crc_nxt = crc_byte(crc_r, body);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      crc_r   <= CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      crc_r   <= crc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= is_verdict ? KIND_VERDICT : KIND_TX;
      byte_r  <= is_verdict ? 8'h00 : body;
      last_r  <= is_last;
      acc_r   <= is_verdict && head.acc;
      exc_r   <= is_verdict && head.exc;
      fm_r    <= is_verdict && head.fm;
      cm_r    <= is_verdict && head.cm;
      alarm_r <= head.alarm;
    end
  end

  assign out_valid             = valid_r;
  assign out_kind              = kind_r;
  assign out_tx_byte           = byte_r;
  assign out_last              = last_r;
  assign out_accepted          = acc_r;
  assign out_exception_seen    = exc_r;
  assign out_function_mismatch = fm_r;
  assign out_crc_mismatch      = cm_r;
  assign out_alarm             = alarm_r;

endmodule

// ===== rtl/core/modbus_rtu_master_frame_engine.sv =====
// top level of the modbus rtu master frame engine
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------------
//   in      | in_valid/in_ready  | op, slave_addr, function_code, rx_byte, frame_first
//   out     | out_valid/out_ready| kind, tx_byte, last, verdict flags, alarm
//
// a request is accepted whenever the 4-entry job queue has room
// results leave at one per cycle while out_ready is high: 8 for a command, 1 or 9 for a frame verdict
// the back end computes the crc of outgoing frames one byte per result
// reset clears all control state; the received header bytes are not reset
// a stalled out channel fills the queue, then in_ready drops
module modbus_rtu_master_frame_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_slave_addr,
  input  logic [7:0] in_function_code,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_first,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_last,
  output logic       out_accepted,
  output logic       out_exception_seen,
  output logic       out_function_mismatch,
  output logic       out_crc_mismatch,
  output logic       out_alarm
);
  import mrtu_pkg::*;

  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  mrtu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_slave_addr    (in_slave_addr),
    .in_function_code (in_function_code),
    .in_rx_byte       (in_rx_byte),
    .in_frame_first   (in_frame_first),
    .q_full           (q_full),
    .push             (push),
    .job              (push_job)
  );

  mrtu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (head_job),
    .full  (q_full),
    .empty (q_empty)
  );

  mrtu_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head_job),
    .q_empty               (q_empty),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_tx_byte           (out_tx_byte),
    .out_last              (out_last),
    .out_accepted          (out_accepted),
    .out_exception_seen    (out_exception_seen),
    .out_function_mismatch (out_function_mismatch),
    .out_crc_mismatch      (out_crc_mismatch),
    .out_alarm             (out_alarm)
  );

endmodule
